[rtl/core/dtq_pkg.sv]
// Shared types, sizes and codes for the delta-list timer queue.
// Used by dtq_alu, delta_timer_queue and dtq_checker; depends on nothing.
package dtq_pkg;

   // sizing of the slot store
   localparam int NUM_TIMERS = 16;
   localparam int DELAY_BITS = 16;
   localparam int SLOT_BITS  = $clog2(NUM_TIMERS);
   localparam int LINK_BITS  = SLOT_BITS + 1;
   localparam int RES_BITS   = DELAY_BITS + 1;
   localparam int GUARD_BITS = $clog2(NUM_TIMERS + 1);

   // fixed widths of the beat fields
   localparam int OP_BITS    = 2;
   localparam int ID_BITS    = 4;
   localparam int TICK_BITS  = 16;

   // link value that marks the end of the list
   localparam logic [LINK_BITS-1:0] NO_SLOT = LINK_BITS'(NUM_TIMERS);
   localparam logic [RES_BITS-1:0]  RES_MAX = '1;

   // operation codes
   localparam logic [OP_BITS-1:0] OP_ADVANCE  = 2'd0;
   localparam logic [OP_BITS-1:0] OP_SCHEDULE = 2'd1;
   localparam logic [OP_BITS-1:0] OP_CANCEL   = 2'd2;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADV_SUM,
      ST_ADV_CMP,
      ST_ADV_SUB,
      ST_UNL_A,
      ST_UNL_B,
      ST_INS_START,
      ST_INS_WALK,
      ST_INS_PLACE
   } state_type;

   // request to the shared add/subtract unit
   typedef struct packed {
      logic                subtract;
      logic [RES_BITS-1:0] op_a;
      logic [RES_BITS-1:0] op_b;
   } alu_req_type;

   // true when a link points at a real slot
   function automatic logic link_valid(input logic [LINK_BITS-1:0] link);
      return link < NO_SLOT;
   endfunction

endpackage

[rtl/core/dtq_alu.sv]
// Shared add/subtract unit of the timer queue sequencer.
// Depends on dtq_pkg for widths and the request struct.
module dtq_alu
   import dtq_pkg::*;
(
   input  alu_req_type         alu_req,
   output logic [RES_BITS:0]   alu_result
);

   logic [RES_BITS:0] op_b_ext;

   // one extra bit: carry out on add, sign (a below b) on subtract
   always_comb begin
      op_b_ext = {1'b0, alu_req.op_b};
      if (alu_req.subtract) begin
         op_b_ext = ~op_b_ext;
      end
      alu_result = {1'b0, alu_req.op_a} + op_b_ext + (RES_BITS + 1)'(alu_req.subtract);
   end

endmodule

[rtl/core/delta_timer_queue.sv]
// Top level of the delta-list timer queue: slot store, list sequencer, result register.
// Depends on dtq_pkg and dtq_alu.
//
//   channel | direction | handshake            | fields
//   req     | in        | req_valid/req_stall  | operation, timer_id, delay_ticks,
//           |           |                      | elapsed_ticks
//   rsp     | out       | rsp_valid/rsp_stall  | expired_id
//
// The list walk reads one linked slot per cycle through the single add/subtract unit.
// Code 3 is taken and does nothing.
// Reset clears the active bits, empties the list and zeroes the residual; links and
// deltas are written before they are read and are not cleared.
// req_stall is high while an item is in work; a held result beat does not block
// intake, only an advance that pops a timer waits for the result register.
module delta_timer_queue
   import dtq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [OP_BITS-1:0]   req_operation,
   input  logic [ID_BITS-1:0]   req_timer_id,
   input  logic [TICK_BITS-1:0] req_delay_ticks,
   input  logic [TICK_BITS-1:0] req_elapsed_ticks,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [ID_BITS-1:0]   rsp_expired_id
);

   // slot store
   logic [DELAY_BITS-1:0] slot_delta_ff [NUM_TIMERS];
   logic [LINK_BITS-1:0]  slot_next_ff  [NUM_TIMERS];
   logic [LINK_BITS-1:0]  slot_prev_ff  [NUM_TIMERS];
   logic [NUM_TIMERS-1:0] slot_active_ff;

   // control and work registers
   state_type             state_ff, state_in;
   logic [LINK_BITS-1:0]  head_ff, head_in;
   logic [RES_BITS-1:0]   residual_ff, residual_in;
   logic [OP_BITS-1:0]    op_ff, op_in;
   logic [SLOT_BITS-1:0]  id_ff, id_in;
   logic [RES_BITS-1:0]   work_ff, work_in;
   logic [LINK_BITS-1:0]  nx_ff, nx_in;
   logic [LINK_BITS-1:0]  pv_ff, pv_in;
   logic [DELAY_BITS-1:0] dl_ff, dl_in;
   logic [SLOT_BITS-1:0]  ptr_ff, ptr_in;
   logic [GUARD_BITS-1:0] guard_ff, guard_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ID_BITS-1:0]    rsp_id_ff, rsp_id_in;

   // read port
   logic [SLOT_BITS-1:0]  rd_idx;
   logic [DELAY_BITS-1:0] rd_delta;
   logic [LINK_BITS-1:0]  rd_next;
   logic [LINK_BITS-1:0]  rd_prev;
   logic                  rd_active;

   // write ports: port a at a chosen slot, port b at the slot being moved
   logic                  dwa_en, dwb_en, nwa_en, nwb_en, pwa_en, pwb_en, act_en;
   logic [SLOT_BITS-1:0]  dwa_addr, nwa_addr, pwa_addr, act_addr;
   logic [DELAY_BITS-1:0] dwa_data, dwb_data;
   logic [LINK_BITS-1:0]  nwa_data, nwb_data, pwa_data, pwb_data;
   logic                  act_data;

   // shared unit
   alu_req_type           alu_req;
   logic [RES_BITS:0]     alu_result;
   logic                  alu_neg;
   logic                  walk_gt;
   logic                  out_free;
   state_type             after_unlink;

   dtq_alu u_alu (
      .alu_req    (alu_req),
      .alu_result (alu_result)
   );

   // read of the slot the sequencer points at
   always_comb begin
      case (state_ff)
         ST_UNL_A:                               rd_idx = id_ff;
         ST_UNL_B:                               rd_idx = nx_ff[SLOT_BITS-1:0];
         ST_INS_WALK, ST_INS_PLACE:              rd_idx = ptr_ff;
         default:                                rd_idx = head_ff[SLOT_BITS-1:0];
      endcase
      rd_delta  = slot_delta_ff[rd_idx];
      rd_next   = slot_next_ff[rd_idx];
      rd_prev   = slot_prev_ff[rd_idx];
      rd_active = slot_active_ff[rd_idx];
   end

   assign alu_neg  = alu_result[RES_BITS];
   assign walk_gt  = !alu_neg && (alu_result[RES_BITS-1:0] != '0);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign after_unlink = (op_ff == OP_SCHEDULE) ? ST_INS_START : ST_IDLE;

   // sequencer: next state, work registers and store writes
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      residual_in  = residual_ff;
      op_in        = op_ff;
      id_in        = id_ff;
      work_in      = work_ff;
      nx_in        = nx_ff;
      pv_in        = pv_ff;
      dl_in        = dl_ff;
      ptr_in       = ptr_ff;
      guard_in     = guard_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_id_in    = rsp_id_ff;

      alu_req.subtract = 1'b1;
      alu_req.op_a     = work_ff;
      alu_req.op_b     = RES_BITS'(rd_delta);

      dwa_en   = 1'b0;
      dwa_addr = rd_idx;
      dwa_data = alu_result[DELAY_BITS-1:0];
      dwb_en   = 1'b0;
      dwb_data = work_ff[DELAY_BITS-1:0];
      nwa_en   = 1'b0;
      nwa_addr = rd_idx;
      nwa_data = LINK_BITS'(id_ff);
      nwb_en   = 1'b0;
      nwb_data = NO_SLOT;
      pwa_en   = 1'b0;
      pwa_addr = rd_idx;
      pwa_data = NO_SLOT;
      pwb_en   = 1'b0;
      pwb_data = NO_SLOT;
      act_en   = 1'b0;
      act_addr = id_ff;
      act_data = 1'b0;

      case (state_ff)
         // take a beat and latch its fields
         ST_IDLE: begin
            if (req_valid) begin
               op_in = req_operation;
               id_in = SLOT_BITS'(req_timer_id);
               if (req_operation == OP_ADVANCE) begin
                  work_in = RES_BITS'(req_elapsed_ticks);
               end else begin
                  work_in = RES_BITS'(req_delay_ticks);
               end
               case (req_operation)
                  OP_ADVANCE:             state_in = ST_ADV_SUM;
                  OP_SCHEDULE, OP_CANCEL: state_in = ST_UNL_A;
                  default:                state_in = ST_IDLE;
               endcase
            end
         end

         // elapsed plus residual, saturated
         ST_ADV_SUM: begin
            alu_req.subtract = 1'b0;
            alu_req.op_b     = residual_ff;
            work_in  = alu_result[RES_BITS] ? RES_MAX : alu_result[RES_BITS-1:0];
            state_in = ST_ADV_CMP;
         end

         // compare against the head; pop it when due
         ST_ADV_CMP: begin
            if (!link_valid(head_ff)) begin
               residual_in = '0;
               state_in    = ST_IDLE;
            end else if (alu_neg) begin
               state_in = ST_ADV_SUB;
            end else if (out_free) begin
               residual_in  = alu_result[RES_BITS-1:0];
               head_in      = rd_next;
               pwa_en       = link_valid(rd_next);
               pwa_addr     = rd_next[SLOT_BITS-1:0];
               act_en       = 1'b1;
               act_addr     = rd_idx;
               rsp_valid_in = 1'b1;
               rsp_id_in    = ID_BITS'(rd_idx);
               state_in     = ST_IDLE;
            end
         end

         // head not due: shrink its delta
         ST_ADV_SUB: begin
            alu_req.op_a = RES_BITS'(rd_delta);
            alu_req.op_b = work_ff;
            dwa_en       = 1'b1;
            residual_in  = '0;
            state_in     = ST_IDLE;
         end

         // unlink: bypass the slot in the forward chain
         ST_UNL_A: begin
            if (rd_active) begin
               nx_in    = rd_next;
               pv_in    = rd_prev;
               dl_in    = rd_delta;
               act_en   = 1'b1;
               nwa_addr = rd_prev[SLOT_BITS-1:0];
               nwa_data = rd_next;
               if (link_valid(rd_prev)) begin
                  nwa_en = 1'b1;
               end else begin
                  head_in = rd_next;
               end
               state_in = link_valid(rd_next) ? ST_UNL_B : after_unlink;
            end else begin
               state_in = after_unlink;
            end
         end

         // unlink: successor takes over the delta and back link
         ST_UNL_B: begin
            alu_req.subtract = 1'b0;
            alu_req.op_a     = RES_BITS'(rd_delta);
            alu_req.op_b     = RES_BITS'(dl_ff);
            dwa_en           = 1'b1;
            pwa_en           = 1'b1;
            pwa_data         = pv_ff;
            state_in         = after_unlink;
         end

         // insert: empty list or start of the walk
         ST_INS_START: begin
            if (!link_valid(head_ff)) begin
               dwb_en   = 1'b1;
               nwb_en   = 1'b1;
               pwb_en   = 1'b1;
               act_en   = 1'b1;
               act_data = 1'b1;
               head_in  = LINK_BITS'(id_ff);
               state_in = ST_IDLE;
            end else begin
               ptr_in   = head_ff[SLOT_BITS-1:0];
               guard_in = '0;
               state_in = ST_INS_WALK;
            end
         end

         // insert: one linked slot per cycle
         ST_INS_WALK: begin
            if (link_valid(rd_next) && walk_gt
                && (guard_ff < GUARD_BITS'(NUM_TIMERS))) begin
               work_in  = alu_result[RES_BITS-1:0];
               ptr_in   = rd_next[SLOT_BITS-1:0];
               guard_in = guard_ff + 1'b1;
            end else if (walk_gt) begin
               // append after the current slot
               dwb_en   = 1'b1;
               dwb_data = alu_result[DELAY_BITS-1:0];
               pwb_en   = 1'b1;
               pwb_data = LINK_BITS'(ptr_ff);
               nwa_en   = 1'b1;
               nwb_en   = 1'b1;
               act_en   = 1'b1;
               act_data = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_INS_PLACE;
            end
         end

         // insert ahead of the current slot
         ST_INS_PLACE: begin
            alu_req.op_a = RES_BITS'(rd_delta);
            alu_req.op_b = work_ff;
            dwa_en       = 1'b1;
            dwb_en       = 1'b1;
            nwa_addr     = rd_prev[SLOT_BITS-1:0];
            if (link_valid(rd_prev)) begin
               nwa_en = 1'b1;
            end else begin
               head_in = LINK_BITS'(id_ff);
            end
            nwb_en   = 1'b1;
            nwb_data = LINK_BITS'(ptr_ff);
            pwb_en   = 1'b1;
            pwb_data = rd_prev;
            pwa_en   = 1'b1;
            pwa_data = LINK_BITS'(id_ff);
            act_en   = 1'b1;
            act_data = 1'b1;
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         head_ff        <= NO_SLOT;
         residual_ff    <= '0;
         slot_active_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         residual_ff  <= residual_in;
         rsp_valid_ff <= rsp_valid_in;
         if (act_en) begin
            slot_active_ff[act_addr] <= act_data;
         end
      end
   end

   // work registers and result payload
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      id_ff     <= id_in;
      work_ff   <= work_in;
      nx_ff     <= nx_in;
      pv_ff     <= pv_in;
      dl_ff     <= dl_in;
      ptr_ff    <= ptr_in;
      guard_ff  <= guard_in;
      rsp_id_ff <= rsp_id_in;
   end

   // slot store writes
   always_ff @(posedge clock) begin
      if (dwa_en) begin
         slot_delta_ff[dwa_addr] <= dwa_data;
      end
      if (dwb_en) begin
         slot_delta_ff[id_ff] <= dwb_data;
      end
      if (nwa_en) begin
         slot_next_ff[nwa_addr] <= nwa_data;
      end
      if (nwb_en) begin
         slot_next_ff[id_ff] <= nwb_data;
      end
      if (pwa_en) begin
         slot_prev_ff[pwa_addr] <= pwa_data;
      end
      if (pwb_en) begin
         slot_prev_ff[id_ff] <= pwb_data;
      end
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_expired_id = rsp_id_ff;

endmodule

[rtl/core/dtq_checker.sv]
// Port-level checks for delta_timer_queue, bound to the top level.
// Depends on dtq_pkg for field widths and operation codes.
module dtq_checker
   import dtq_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic [OP_BITS-1:0]   req_operation,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [ID_BITS-1:0]   rsp_expired_id
);

   // no result beat right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // any real operation keeps the block busy for the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall
       && (req_operation == OP_ADVANCE || req_operation == OP_SCHEDULE
           || req_operation == OP_CANCEL)) |=> req_stall)
      else $error("block idle right after taking an operation");

   // a new result beat comes out of work, never out of idle
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result beat without an advance in work");

   // a held result beat keeps its slot number
   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_expired_id)))
      else $error("held result beat changed");

endmodule

bind delta_timer_queue dtq_checker u_dtq_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_operation  (req_operation),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_expired_id (rsp_expired_id)
);

[dv/delta_timer_queue_tb.sv]
// Self-checking bench for delta_timer_queue: directed table, then random schedule,
// cancel, advance and code 3 beats checked against a delta-list predictor in this file.
// Depends on dtq_pkg and the delta_timer_queue RTL.
module delta_timer_queue_tb;
   import dtq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [OP_BITS-1:0] OP_NOOP = 2'd3;
   localparam int RANDOM_ITEMS     = 600;
   localparam int LONG_HOLD_CYCLES = 200;
   localparam int CYCLE_LIMIT      = 300000;
   localparam int DRAIN_CYCLES     = 40;

   // how a table row gets its expected result
   typedef enum logic [1:0] {
      ROW_MODEL,
      ROW_QUIET,
      ROW_FIRES
   } row_kind_type;

   typedef struct packed {
      logic [OP_BITS-1:0]   op;
      logic [ID_BITS-1:0]   id;
      logic [TICK_BITS-1:0] dly;
      logic [TICK_BITS-1:0] elp;
      row_kind_type         kind;
      logic [ID_BITS-1:0]   want;
   } row_type;

   localparam int PLAN_ROWS = 24;
   localparam row_type PLAN [PLAN_ROWS] = '{
      // empty queue, unknown code, idle cancel
      '{OP_ADVANCE,  4'd0,  16'h0000, 16'h0000, ROW_QUIET, 4'd0},
      '{OP_ADVANCE,  4'd0,  16'h0000, 16'hFFFF, ROW_QUIET, 4'd0},
      '{OP_NOOP,     4'd15, 16'hFFFF, 16'hFFFF, ROW_QUIET, 4'd0},
      '{OP_CANCEL,   4'd5,  16'h0000, 16'h0000, ROW_QUIET, 4'd0},
      // extremes of delay, equal delay goes ahead
      '{OP_SCHEDULE, 4'd0,  16'h0000, 16'h0000, ROW_QUIET, 4'd0},
      '{OP_SCHEDULE, 4'd15, 16'hFFFF, 16'h0000, ROW_QUIET, 4'd0},
      '{OP_SCHEDULE, 4'd1,  16'h0000, 16'h0000, ROW_QUIET, 4'd0},
      '{OP_ADVANCE,  4'd0,  16'h0000, 16'h0000, ROW_FIRES, 4'd1},
      '{OP_ADVANCE,  4'd0,  16'h0000, 16'h0000, ROW_FIRES, 4'd0},
      '{OP_ADVANCE,  4'd0,  16'h0000, 16'hFFFF, ROW_FIRES, 4'd15},
      // residual climbs to saturation, then carries past a long delay
      '{OP_SCHEDULE, 4'd2,  16'h0000, 16'h0000, ROW_QUIET, 4'd0},
      '{OP_SCHEDULE, 4'd3,  16'h0000, 16'h0000, ROW_QUIET, 4'd0},
      '{OP_SCHEDULE, 4'd4,  16'h0000, 16'h0000, ROW_QUIET, 4'd0},
      '{OP_ADVANCE,  4'd0,  16'h0000, 16'hFFFF, ROW_MODEL, 4'd0},
      '{OP_ADVANCE,  4'd0,  16'h0000, 16'hFFFF, ROW_MODEL, 4'd0},
      '{OP_ADVANCE,  4'd0,  16'h0000, 16'hFFFF, ROW_MODEL, 4'd0},
      '{OP_SCHEDULE, 4'd7,  16'hFFFF, 16'h0000, ROW_QUIET, 4'd0},
      '{OP_ADVANCE,  4'd0,  16'h0000, 16'h0000, ROW_MODEL, 4'd0},
      '{OP_ADVANCE,  4'd0,  16'h0000, 16'h0000, ROW_QUIET, 4'd0},
      // reschedule of a listed timer, cancel that hands its delta on
      '{OP_SCHEDULE, 4'd8,  16'd100,  16'h0000, ROW_QUIET, 4'd0},
      '{OP_SCHEDULE, 4'd9,  16'd50,   16'h0000, ROW_QUIET, 4'd0},
      '{OP_SCHEDULE, 4'd8,  16'd10,   16'h0000, ROW_QUIET, 4'd0},
      '{OP_CANCEL,   4'd8,  16'h0000, 16'h0000, ROW_QUIET, 4'd0},
      '{OP_ADVANCE,  4'd0,  16'h0000, 16'd50,   ROW_MODEL, 4'd0}
   };

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [OP_BITS-1:0]   req_operation;
   logic [ID_BITS-1:0]   req_timer_id;
   logic [TICK_BITS-1:0] req_delay_ticks;
   logic [TICK_BITS-1:0] req_elapsed_ticks;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [ID_BITS-1:0]   rsp_expired_id;

   // predicted list state
   logic [DELAY_BITS-1:0] rel_delay [NUM_TIMERS];
   logic [LINK_BITS-1:0]  link_next [NUM_TIMERS];
   logic [LINK_BITS-1:0]  link_prev [NUM_TIMERS];
   bit                    listed    [NUM_TIMERS];
   logic [LINK_BITS-1:0]  head_link;
   logic [RES_BITS-1:0]   carry_ticks;

   logic [ID_BITS-1:0] expiry_q [$];
   int  mismatches  = 0;
   int  cycle_count = 0;
   bit  calm        = 1'b0;
   bit  long_hold   = 1'b0;

   delta_timer_queue uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_timer_id      (req_timer_id),
      .req_delay_ticks   (req_delay_ticks),
      .req_elapsed_ticks (req_elapsed_ticks),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_expired_id    (rsp_expired_id)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("delta_timer_queue verification failed");
         $finish;
      end
   end

   // unlink a listed slot, its successor absorbs the delta
   function automatic void drop_slot(input logic [SLOT_BITS-1:0] s);
      logic [LINK_BITS-1:0] nx;
      logic [LINK_BITS-1:0] pv;
      if (!listed[s])
         return;
      nx = link_next[s];
      pv = link_prev[s];
      if (nx != NO_SLOT) begin
         rel_delay[nx[SLOT_BITS-1:0]] = rel_delay[nx[SLOT_BITS-1:0]] + rel_delay[s];
         link_prev[nx[SLOT_BITS-1:0]] = pv;
      end
      if (pv != NO_SLOT)
         link_next[pv[SLOT_BITS-1:0]] = nx;
      else
         head_link = nx;
      listed[s] = 1'b0;
   endfunction

   // apply one beat to the predicted list; returns 1 when a timer expires
   function automatic bit predict_expiry(input logic [OP_BITS-1:0] op,
                                         input logic [ID_BITS-1:0] id,
                                         input logic [TICK_BITS-1:0] dly,
                                         input logic [TICK_BITS-1:0] elp,
                                         output logic [ID_BITS-1:0] fired);
      logic [RES_BITS:0]     sum;
      logic [RES_BITS-1:0]   due;
      logic [SLOT_BITS-1:0]  h;
      logic [SLOT_BITS-1:0]  pt;
      logic [DELAY_BITS-1:0] d;
      logic [LINK_BITS-1:0]  pv;
      int                    guard;
      fired = '0;
      case (op)
         OP_ADVANCE: begin
            sum = {1'b0, carry_ticks} + (RES_BITS + 1)'(elp);
            due = (sum > (RES_BITS + 1)'(RES_MAX)) ? RES_MAX : sum[RES_BITS-1:0];
            if (head_link == NO_SLOT) begin
               carry_ticks = '0;
               return 1'b0;
            end
            h = head_link[SLOT_BITS-1:0];
            // head not yet due: shrink it
            if (RES_BITS'(rel_delay[h]) > due) begin
               rel_delay[h] = rel_delay[h] - due[DELAY_BITS-1:0];
               carry_ticks = '0;
               return 1'b0;
            end
            // pop the head and carry the overshoot
            carry_ticks = due - RES_BITS'(rel_delay[h]);
            head_link = link_next[h];
            if (head_link != NO_SLOT)
               link_prev[head_link[SLOT_BITS-1:0]] = NO_SLOT;
            listed[h] = 1'b0;
            fired = ID_BITS'(h);
            return 1'b1;
         end
         OP_SCHEDULE: begin
            drop_slot(id);
            d = DELAY_BITS'(dly);
            if (head_link == NO_SLOT) begin
               link_next[id] = NO_SLOT;
               link_prev[id] = NO_SLOT;
               rel_delay[id] = d;
               head_link = LINK_BITS'(id);
            end else begin
               // walk past entries that expire strictly earlier
               pt = head_link[SLOT_BITS-1:0];
               guard = 0;
               while (link_next[pt] != NO_SLOT && d > rel_delay[pt] && guard < NUM_TIMERS) begin
                  d = d - rel_delay[pt];
                  pt = link_next[pt][SLOT_BITS-1:0];
                  guard++;
               end
               if (d <= rel_delay[pt]) begin
                  pv = link_prev[pt];
                  rel_delay[pt] = rel_delay[pt] - d;
                  if (pv != NO_SLOT)
                     link_next[pv[SLOT_BITS-1:0]] = LINK_BITS'(id);
                  else
                     head_link = LINK_BITS'(id);
                  link_prev[id] = pv;
                  link_prev[pt] = LINK_BITS'(id);
                  link_next[id] = LINK_BITS'(pt);
                  rel_delay[id] = d;
               end else begin
                  rel_delay[id] = d - rel_delay[pt];
                  link_prev[id] = LINK_BITS'(pt);
                  link_next[pt] = LINK_BITS'(id);
                  link_next[id] = NO_SLOT;
               end
            end
            listed[id] = 1'b1;
         end
         OP_CANCEL: drop_slot(id);
         default: ;
      endcase
      return 1'b0;
   endfunction

   // tick counts weighted toward small values so timers expire often
   function automatic logic [TICK_BITS-1:0] pick_ticks();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2, 3: return TICK_BITS'($urandom);
         4, 5: return TICK_BITS'($urandom_range(0, 2000));
         default: return TICK_BITS'($urandom_range(0, 60));
      endcase
   endfunction

   // offer one request beat, wait for it to be taken, record what it should cause
   task automatic offer_beat(input logic [OP_BITS-1:0] op, input logic [ID_BITS-1:0] id,
                             input logic [TICK_BITS-1:0] dly,
                             input logic [TICK_BITS-1:0] elp,
                             input row_kind_type kind, input logic [ID_BITS-1:0] want);
      int unsigned        gap;
      bit                 pops;
      logic [ID_BITS-1:0] fired;
      gap = calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_timer_id      <= id;
      req_delay_ticks   <= dly;
      req_elapsed_ticks <= elp;
      do @(posedge clock); while (req_stall);
      pops = predict_expiry(op, id, dly, elp, fired);
      case (kind)
         ROW_QUIET: ;
         ROW_FIRES: expiry_q.push_back(want);
         default: if (pops) expiry_q.push_back(fired);
      endcase
      @(negedge clock);
   endtask

   // result side: random stall after each beat, long hold-off on request
   initial begin : rsp_side
      int unsigned        hold;
      logic [ID_BITS-1:0] want;
      hold = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            if (expiry_q.size() == 0) begin
               $display("%0t: expired_id expected none, got %0d", $time, rsp_expired_id);
               mismatches++;
            end else begin
               want = expiry_q.pop_front();
               if (rsp_expired_id !== want) begin
                  $display("%0t: expired_id expected %0d, got %0d", $time, want,
                           rsp_expired_id);
                  mismatches++;
               end
            end
            hold = calm ? 0 : $urandom_range(0, 5);
         end
         @(negedge clock);
         if (long_hold) begin
            hold = LONG_HOLD_CYCLES;
            long_hold = 1'b0;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // request side: reset, directed table, random beats, drain
   initial begin : req_side
      int                   counted;
      int                   k;
      int unsigned          sel;
      logic [OP_BITS-1:0]   op;
      logic [ID_BITS-1:0]   id;
      logic [TICK_BITS-1:0] dly;
      logic [TICK_BITS-1:0] elp;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_operation     = OP_ADVANCE;
      req_timer_id      = '0;
      req_delay_ticks   = '0;
      req_elapsed_ticks = '0;
      rsp_stall         = 1'b0;
      for (k = 0; k < NUM_TIMERS; k++) begin
         listed[k]    = 1'b0;
         rel_delay[k] = '0;
         link_next[k] = NO_SLOT;
         link_prev[k] = NO_SLOT;
      end
      head_link   = NO_SLOT;
      carry_ticks = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // directed table
      for (k = 0; k < PLAN_ROWS; k++)
         offer_beat(PLAN[k].op, PLAN[k].id, PLAN[k].dly, PLAN[k].elp, PLAN[k].kind,
                    PLAN[k].want);

      // random beats
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         if (counted == 150)
            calm = 1'b1;
         if (counted == 220)
            calm = 1'b0;
         if (counted == 300) begin
            // hold the result side off while pops pile up behind it
            long_hold = 1'b1;
            for (k = 0; k < 6; k++) begin
               offer_beat(OP_SCHEDULE, ID_BITS'($urandom_range(0, 15)), '0,
                          TICK_BITS'($urandom), ROW_MODEL, '0);
            end
            for (k = 0; k < 8; k++) begin
               offer_beat(OP_ADVANCE, ID_BITS'($urandom), TICK_BITS'($urandom), '0,
                          ROW_MODEL, '0);
            end
            counted += 14;
         end
         if (counted == 450) begin
            // let every pending expiry come out before going on
            req_valid <= 1'b0;
            do @(negedge clock); while (expiry_q.size() != 0);
         end
         sel = $urandom_range(0, 99);
         id  = ID_BITS'($urandom_range(0, 15));
         dly = TICK_BITS'($urandom);
         elp = TICK_BITS'($urandom);
         if (sel < 40) begin
            op  = OP_ADVANCE;
            elp = pick_ticks();
         end else if (sel < 80) begin
            op  = OP_SCHEDULE;
            dly = pick_ticks();
         end else if (sel < 95) begin
            op = OP_CANCEL;
            // mostly aim at a listed timer
            if ($urandom_range(0, 3) != 0) begin
               for (k = 0; k < NUM_TIMERS && !listed[id]; k++)
                  id = ID_BITS'($urandom_range(0, 15));
            end
         end else begin
            op = OP_NOOP;
         end
         if (op != OP_NOOP && !(op == OP_CANCEL && !listed[id]))
            counted++;
         offer_beat(op, id, dly, elp, ROW_MODEL, '0);
      end

      // drain
      req_valid <= 1'b0;
      while (expiry_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0)
         $display("delta_timer_queue verification clean");
      else
         $display("delta_timer_queue verification failed");
      $finish;
   end

endmodule
